FILE: sv/npcs_pkg.sv
// Shared types and constants for the nearest palette colour search.
package npcs_pkg;

  localparam int CHAN_W = 8;
  localparam int ENTRY_W = 3 * CHAN_W;
  localparam int IDX_W = 8;
  localparam int DIST_W = 11;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } item_t;

endpackage

FILE: sv/nearest_palette_color_search.sv
// Top level of the nearest palette colour search.
// Input channel: a request is taken at a clock edge with push high and full low.
// kind low loads red, green, blue into palette entry entry_index; entries at or
// beyond PALETTE_ENTRIES are ignored. kind high matches the pixel against every
// entry by 3*|dR| + 2*|dG| + |dB|, lowest index on equal distances.
// Result channel: while empty is low, color_index and best_distance hold the
// oldest result; it leaves at an edge with pop high and empty low.
// Loads give no result. A pixel search reads one palette entry per cycle
// from the single memory read port, then stores the result.
// A two-entry request queue takes new requests while a search runs.
// If the result is not popped, the next search finishes and then waits;
// full rises once the queue fills.
// Synchronous reset empties both sides and sets every palette entry to black.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [npcs_pkg::IDX_W-1:0]  entry_index,
  input  logic [npcs_pkg::CHAN_W-1:0] red,
  input  logic [npcs_pkg::CHAN_W-1:0] green,
  input  logic [npcs_pkg::CHAN_W-1:0] blue,
  output logic                        empty,
  input  logic                        pop,
  output logic [npcs_pkg::IDX_W-1:0]  color_index,
  output logic [npcs_pkg::DIST_W-1:0] best_distance
);

  logic            q_valid;
  logic            q_take;
  npcs_pkg::item_t q_item;

  npcs_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_item      (q_item)
  );

  npcs_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_take        (q_take),
    .q_item        (q_item),
    .res_empty     (empty),
    .res_pop       (pop),
    .color_index   (color_index),
    .best_distance (best_distance)
  );

endmodule

FILE: sv/npcs_front.sv
// Front part: accepts requests, drops loads beyond the palette, holds a two-entry queue.
module npcs_front #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind,
  input  logic [npcs_pkg::IDX_W-1:0]  entry_index,
  input  logic [npcs_pkg::CHAN_W-1:0] red,
  input  logic [npcs_pkg::CHAN_W-1:0] green,
  input  logic [npcs_pkg::CHAN_W-1:0] blue,
  output logic                      q_valid,
  input  logic                      q_take,
  output npcs_pkg::item_t           q_item
);

  npcs_pkg::item_t slots [2];
  npcs_pkg::item_t in_item;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       deq;

  always_comb begin
    in_item.op    = kind ? npcs_pkg::OP_PIXEL : npcs_pkg::OP_LOAD;
    in_item.idx   = entry_index;
    in_item.red   = red;
    in_item.green = green;
    in_item.blue  = blue;
  end

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign keep    = accept && (kind || ({1'b0, entry_index} < 9'(PALETTE_ENTRIES)));
  assign q_valid = (count != 2'd0);
  assign deq     = q_take && q_valid;
  assign q_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (keep) begin
      slots[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (keep) begin
        wptr <= ~wptr;
      end
      if (deq) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(keep) - 2'(deq);
    end
  end

endmodule

FILE: sv/npcs_back.sv
// Back part: palette memory, sequential search and result register.
module npcs_back #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_take,
  input  npcs_pkg::item_t             q_item,
  output logic                        res_empty,
  input  logic                        res_pop,
  output logic [npcs_pkg::IDX_W-1:0]  color_index,
  output logic [npcs_pkg::DIST_W-1:0] best_distance
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [npcs_pkg::ENTRY_W-1:0] mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]   loaded;
  logic [npcs_pkg::ENTRY_W-1:0] rdata;
  logic                         rvld;
  logic [AW-1:0]                cnt;
  logic                         pipe_vld;
  logic [AW-1:0]                pipe_idx;
  logic [npcs_pkg::CHAN_W-1:0]  px_r;
  logic [npcs_pkg::CHAN_W-1:0]  px_g;
  logic [npcs_pkg::CHAN_W-1:0]  px_b;
  logic [AW-1:0]                best_idx;
  logic [npcs_pkg::DIST_W-1:0]  best;
  logic                         res_full;
  logic                         we;
  logic                         start;
  logic                         issue;
  logic                         update;
  logic [npcs_pkg::CHAN_W-1:0]  ent_r;
  logic [npcs_pkg::CHAN_W-1:0]  ent_g;
  logic [npcs_pkg::CHAN_W-1:0]  ent_b;
  logic [npcs_pkg::CHAN_W-1:0]  ad_r;
  logic [npcs_pkg::CHAN_W-1:0]  ad_g;
  logic [npcs_pkg::CHAN_W-1:0]  ad_b;
  logic [npcs_pkg::DIST_W-1:0]  wdist;

  assign q_take = (state == S_IDLE) && q_valid;
  assign we     = q_take && (q_item.op == npcs_pkg::OP_LOAD);
  assign start  = q_take && (q_item.op == npcs_pkg::OP_PIXEL);
  assign issue  = (state == S_SCAN);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[q_item.idx[AW-1:0]] <= {q_item.red, q_item.green, q_item.blue};
    end
    rdata <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (we) begin
      loaded[q_item.idx[AW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    ent_r = rvld ? rdata[3*npcs_pkg::CHAN_W-1:2*npcs_pkg::CHAN_W] : '0;
    ent_g = rvld ? rdata[2*npcs_pkg::CHAN_W-1:npcs_pkg::CHAN_W] : '0;
    ent_b = rvld ? rdata[npcs_pkg::CHAN_W-1:0] : '0;
    ad_r  = (px_r > ent_r) ? px_r - ent_r : ent_r - px_r;
    ad_g  = (px_g > ent_g) ? px_g - ent_g : ent_g - px_g;
    ad_b  = (px_b > ent_b) ? px_b - ent_b : ent_b - px_b;
    wdist = npcs_pkg::DIST_W'({ad_r, 1'b0}) + npcs_pkg::DIST_W'(ad_r)
          + npcs_pkg::DIST_W'({ad_g, 1'b0}) + npcs_pkg::DIST_W'(ad_b);
    update = pipe_vld && ((pipe_idx == '0) || (wdist < best));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == LAST) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pipe_vld <= 1'b0;
      res_full <= 1'b0;
      cnt      <= '0;
    end else begin
      state    <= state_next;
      pipe_vld <= issue;
      if (start) begin
        cnt <= '0;
      end else if (issue && (cnt != LAST)) begin
        cnt <= cnt + 1'b1;
      end
      if ((state == S_EMIT) && !res_full) begin
        res_full <= 1'b1;
      end else if (res_pop && res_full) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rvld     <= loaded[cnt];
    pipe_idx <= cnt;
    if (start) begin
      px_r <= q_item.red;
      px_g <= q_item.green;
      px_b <= q_item.blue;
    end
    if (update) begin
      best     <= wdist;
      best_idx <= pipe_idx;
    end
    if ((state == S_EMIT) && !res_full) begin
      color_index   <= npcs_pkg::IDX_W'(best_idx);
      best_distance <= best;
    end
  end

  assign res_empty = !res_full;

endmodule
